[src/pointer_travel_odometer_assert.svh]
// Assertion macros shared by the odometer modules
`ifndef POINTER_TRAVEL_ODOMETER_ASSERT_SVH
`define POINTER_TRAVEL_ODOMETER_ASSERT_SVH
`ifndef SYNTHESIS
// check an implication on every clock edge outside reset
`define PTODO_ASSERT(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);
// check that a condition is followed by another in the next cycle
`define PTODO_ASSERT_NEXT(lbl, ck, rn, cond, nxt, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (cond) |=> (nxt)) else $error(msg);
`else
`define PTODO_ASSERT(lbl, ck, rn, prop, msg)
`define PTODO_ASSERT_NEXT(lbl, ck, rn, cond, nxt, msg)
`endif
`endif

[src/ptodo_pkg.sv]
`default_nettype none
package ptodo_pkg;

	localparam int COORD_BITS    = 12;
	localparam int ACC_BITS      = 56;
	localparam int IPP_BITS      = 32;
	localparam int INCH_PER_FOOT = 12;
	localparam int FEET_PER_MILE = 5280;
	localparam int DIV_W         = 64;
	localparam int DIV_D_BITS    = 13;
	localparam int DIG_M_BITS    = 14;

	localparam logic [ACC_BITS-1:0]   ACC_MAX    = {ACC_BITS{1'b1}};
	localparam logic [DIV_D_BITS-1:0] DIV_FOOT   = DIV_D_BITS'(INCH_PER_FOOT);
	localparam logic [DIV_D_BITS-1:0] DIV_MILE   = DIV_D_BITS'(FEET_PER_MILE);
	localparam logic [DIG_M_BITS-1:0] DIG_M_INCH = 14'd100;
	localparam logic [DIG_M_BITS-1:0] DIG_M_FOOT = 14'd1000;
	localparam logic [DIG_M_BITS-1:0] DIG_M_MILE = 14'd10000;

	// configuration register indexes
	localparam logic [1:0] CFG_ENABLED = 2'd0;
	localparam logic [1:0] CFG_IPP     = 2'd1;

	typedef enum logic [1:0] {
		REQ_SAMPLE   = 2'd0,
		REQ_RST_TRIP = 2'd1,
		REQ_RST_ALL  = 2'd2,
		REQ_UNUSED   = 2'd3
	} req_code_t;

	typedef enum logic [1:0] {
		UNIT_INCH = 2'd0,
		UNIT_FOOT = 2'd1,
		UNIT_MILE = 2'd2
	} unit_t;

	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_MOVE,
		CMD_RST_TRIP,
		CMD_RST_ALL
	} cmd_kind_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_ROOT,
		BK_MUL,
		BK_DFT,
		BK_DMI,
		BK_ADD,
		BK_RTOT,
		BK_RTRIP,
		BK_FIN,
		BK_OUT
	} back_state_t;

	typedef struct packed {
		logic [1:0]            req_type;
		logic [COORD_BITS-1:0] pos_x;
		logic [COORD_BITS-1:0] pos_y;
	} req_word_t;

	typedef struct packed {
		logic                changed;
		logic [ACC_BITS-1:0] total_value;
		logic [1:0]          total_unit;
		logic [ACC_BITS-1:0] trip_value;
		logic [1:0]          trip_unit;
	} res_word_t;

	// classified work passed from front to back
	typedef struct packed {
		cmd_kind_t             kind;
		logic [COORD_BITS-1:0] dx;
		logic [COORD_BITS-1:0] dy;
	} cmd_t;

	typedef struct packed {
		logic push;
		logic full;
	} q_wr_ctl_t;

	typedef struct packed {
		logic pop;
		logic empty;
	} q_rd_ctl_t;

endpackage
`default_nettype wire

[src/ptodo_front.sv]
`default_nettype none
module ptodo_front import ptodo_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_stall,
	input  wire req_word_t req,
	input  wire logic      enabled,
	input  wire logic      q_full,
	output logic           push,
	output cmd_t           cmd
);

	logic [COORD_BITS-1:0] prev_x_q, prev_y_q;
	logic                  accept;
	logic                  moved;

	assign req_stall = q_full;
	assign accept    = req_valid && !req_stall;
	assign push      = accept;

	// classify the word and take distances
	always_comb begin
		moved    = (prev_x_q != '0 || prev_y_q != '0) &&
			(prev_x_q != req.pos_x || prev_y_q != req.pos_y);
		cmd.dx   = (req.pos_x > prev_x_q) ? req.pos_x - prev_x_q : prev_x_q - req.pos_x;
		cmd.dy   = (req.pos_y > prev_y_q) ? req.pos_y - prev_y_q : prev_y_q - req.pos_y;
		cmd.kind = CMD_NONE;
		unique case (req.req_type)
			REQ_SAMPLE:   cmd.kind = (enabled && moved) ? CMD_MOVE : CMD_NONE;
			REQ_RST_TRIP: cmd.kind = CMD_RST_TRIP;
			REQ_RST_ALL:  cmd.kind = CMD_RST_ALL;
			default:      cmd.kind = CMD_NONE;
		endcase
	end

	// hold the last position seen while enabled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q <= '0;
			prev_y_q <= '0;
		end else if (accept && req.req_type == REQ_SAMPLE && enabled) begin
			prev_x_q <= req.pos_x;
			prev_y_q <= req.pos_y;
		end
	end

endmodule
`default_nettype wire

[src/ptodo_queue.sv]
`default_nettype none
`include "pointer_travel_odometer_assert.svh"
module ptodo_queue import ptodo_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire q_wr_ctl_t wr_in,
	output logic           full,
	input  wire cmd_t      wr_data,
	input  wire q_rd_ctl_t rd_in,
	output logic           empty,
	output cmd_t           head
);

	localparam int DEPTH = 2;

	cmd_t       slot_q [DEPTH];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push, do_pop;

	assign full    = (count_q == 2'(DEPTH));
	assign empty   = (count_q == '0);
	assign head    = slot_q[rd_ptr_q];
	assign do_push = wr_in.push && !full;
	assign do_pop  = rd_in.pop && !empty;

	// store pushed words
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
			if (do_push && !do_pop)      count_q <= count_q + 2'd1;
			else if (do_pop && !do_push) count_q <= count_q - 2'd1;
		end
	end

	`PTODO_ASSERT(a_q_count_max, clk, arst_n, count_q <= 2'(DEPTH), "queue count overflow")
	`PTODO_ASSERT(a_q_pop_nonempty, clk, arst_n, rd_in.pop |-> !rd_in.empty && !empty, "pop from empty queue")

endmodule
`default_nettype wire

[src/ptodo_div.sv]
`default_nettype none
`include "pointer_travel_odometer_assert.svh"
module ptodo_div import ptodo_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [DIV_W-1:0]      dividend,
	input  wire logic [DIV_D_BITS-1:0] divisor,
	output logic                       done,
	output logic [DIV_W-1:0]           quotient
);

	// long division by 12 or 5280, 16 dividend bits per digit; for each digit,
	// estimate the digit by reciprocal multiply, then take the remainder
	localparam int DIG_BITS = 16;
	localparam int DIGITS   = DIV_W / DIG_BITS;
	localparam int CNT_W    = $clog2(DIGITS);
	localparam int V_W      = DIV_D_BITS + DIG_BITS;
	localparam int RCP_W    = 29;
	localparam int EST_W    = V_W + RCP_W;
	localparam int SH_FOOT  = 24;
	localparam int SH_MILE  = 41;
	localparam logic [RCP_W-1:0] RCP_FOOT = 29'd1398102;
	localparam logic [RCP_W-1:0] RCP_MILE = 29'd416481678;

	logic [DIV_W-1:0]      q_q;
	logic [DIV_D_BITS-1:0] rem_q, dvs_q, rem_nx;
	logic                  mile_q;
	logic [DIG_BITS-1:0]   qd_q, qd_nx;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q, phase_q, done_q;
	logic [V_W-1:0]        v, qd_prod;
	logic [RCP_W-1:0]      rcp;
	logic [EST_W-1:0]      est;

	assign done     = done_q;
	assign quotient = q_q;

	// digit estimate and remainder of the current step
	assign v       = {rem_q, q_q[DIV_W-1:DIV_W-DIG_BITS]};
	assign rcp     = mile_q ? RCP_MILE : RCP_FOOT;
	assign est     = EST_W'(v) * EST_W'(rcp);
	assign qd_nx   = mile_q ? DIG_BITS'(est >> SH_MILE) : DIG_BITS'(est >> SH_FOOT);
	assign qd_prod = V_W'(qd_q) * V_W'(dvs_q);
	assign rem_nx  = DIV_D_BITS'(v - qd_prod);

	// hold operands, take a digit, then shift it in
	always_ff @(posedge clk) begin
		if (start) begin
			q_q    <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
			mile_q <= (divisor == DIV_MILE);
		end else if (busy_q) begin
			if (!phase_q) begin
				qd_q <= qd_nx;
			end else begin
				rem_q <= rem_nx;
				q_q   <= {q_q[DIV_W-DIG_BITS-1:0], qd_q};
			end
		end
	end

	// count digits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				phase_q <= 1'b0;
				cnt_q   <= '0;
			end else if (busy_q) begin
				phase_q <= ~phase_q;
				if (phase_q) begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DIGITS - 1)) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	`PTODO_ASSERT(a_div_start_idle, clk, arst_n, start |-> !busy_q, "divider restarted while busy")
	`PTODO_ASSERT_NEXT(a_div_start_busy, clk, arst_n, start, busy_q && !done_q, "divider did not start")
	`PTODO_ASSERT(a_div_known_dvs, clk, arst_n, start |-> (divisor == DIV_FOOT || divisor == DIV_MILE), "unsupported divisor")

endmodule
`default_nettype wire

[src/ptodo_back.sv]
`default_nettype none
`include "pointer_travel_odometer_assert.svh"
module ptodo_back import ptodo_pkg::*; #(
	parameter int FRAC_BITS      = 32,
	parameter int ROOT_FRAC_BITS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [IPP_BITS-1:0] ipp,
	input  wire q_rd_ctl_t           q_in,
	output q_rd_ctl_t                q_out,
	input  wire cmd_t                cmd,
	output logic                     res_valid,
	input  wire logic                res_stall,
	output res_word_t                res
);

	localparam int ROOT_STEPS = COORD_BITS + ROOT_FRAC_BITS + 1;
	localparam int ROOT_W     = ROOT_STEPS;
	localparam int SQ_W       = 2 * ROOT_STEPS;
	localparam int CNT_W      = $clog2(ROOT_STEPS);
	localparam int SUM_W      = 2 * COORD_BITS + 1;
	localparam int PROD_W     = ROOT_W + IPP_BITS;
	localparam int SHIFT      = ROOT_FRAC_BITS + IPP_BITS - FRAC_BITS;
	localparam int EXT_W      = (PROD_W > DIV_W) ? PROD_W : DIV_W;
	localparam int INT_W      = ACC_BITS - FRAC_BITS;
	localparam int DIG_W      = INT_W + DIG_M_BITS + 1;
	localparam int FM_W       = FRAC_BITS + DIG_M_BITS;
	localparam logic [ACC_BITS-1:0] FOOT_LIM =
		ACC_BITS'(64'(INCH_PER_FOOT) << FRAC_BITS);
	localparam logic [ACC_BITS-1:0] MILE_LIM =
		ACC_BITS'(64'(FEET_PER_MILE) << FRAC_BITS);

	back_state_t state_q, state_nx;

	logic [SQ_W-1:0]     sq_q;
	logic [ROOT_W-1:0]   root_q;
	logic [ROOT_W+1:0]   rrem_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [DIV_W-1:0]    inch_q, feet_q, mile_q;
	logic [ACC_BITS-1:0] sum_tot_q, sum_trip_q;
	unit_t               nu_tot_q, nu_trip_q;
	logic                rise_tot_q, rise_trip_q;
	logic [DIG_W-1:0]    odig_tot_q, odig_trip_q;
	logic                issued_q, chg_q;
	logic [ACC_BITS-1:0] acc_tot_q, acc_trip_q;
	unit_t               unit_tot_q, unit_trip_q;
	logic                res_valid_q;
	res_word_t           res_q;

	logic                  pop, load_res, div_start, div_done;
	logic [DIV_W-1:0]      div_dvd, div_quo;
	logic [DIV_D_BITS-1:0] div_dvs;
	logic [SUM_W-1:0]      sq_sum;
	logic [ROOT_W+1:0]     rrem_sh, rtrial;
	logic [PROD_W-1:0]     prod;
	logic [EXT_W-1:0]      prod_sh;
	logic [DIV_W-1:0]      inch_nx;
	logic [ACC_BITS-1:0]   add_tot, add_trip;

	// value shown on the display: floor(acc * M) for the unit's M
	function automatic logic [DIG_W-1:0] digit(logic [ACC_BITS-1:0] a, unit_t u);
		logic [DIG_M_BITS-1:0] m;
		logic [FM_W-1:0]       fm;
		case (u)
			UNIT_INCH: m = DIG_M_INCH;
			UNIT_FOOT: m = DIG_M_FOOT;
			default:   m = DIG_M_MILE;
		endcase
		fm = FM_W'(a[FRAC_BITS-1:0]) * FM_W'(m);
		return DIG_W'(a[ACC_BITS-1:FRAC_BITS]) * DIG_W'(m) + DIG_W'(fm >> FRAC_BITS);
	endfunction

	// saturating add of the amount in the odometer's unit
	function automatic logic [ACC_BITS-1:0] add_sat(logic [ACC_BITS-1:0] a, unit_t u,
		logic [DIV_W-1:0] i, logic [DIV_W-1:0] f, logic [DIV_W-1:0] mi);
		logic [DIV_W-1:0] amt;
		logic [DIV_W:0]   s;
		case (u)
			UNIT_INCH: amt = i;
			UNIT_FOOT: amt = f;
			default:   amt = mi;
		endcase
		s = {1'b0, amt} + (DIV_W + 1)'(a);
		return (s > (DIV_W + 1)'(ACC_MAX)) ? ACC_MAX : s[ACC_BITS-1:0];
	endfunction

	assign q_out.pop   = pop;
	assign q_out.empty = q_in.empty;
	assign res_valid   = res_valid_q;
	assign res         = res_q;

	ptodo_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			BK_IDLE:  if (!q_in.empty) state_nx = (cmd.kind == CMD_MOVE) ? BK_ROOT : BK_OUT;
			BK_ROOT:  if (cnt_q == CNT_W'(ROOT_STEPS - 1)) state_nx = BK_MUL;
			BK_MUL:   state_nx = BK_DFT;
			BK_DFT:   if (div_done) state_nx = BK_DMI;
			BK_DMI:   if (div_done) state_nx = BK_ADD;
			BK_ADD:   state_nx = BK_RTOT;
			BK_RTOT:  if (!rise_tot_q || div_done) state_nx = BK_RTRIP;
			BK_RTRIP: if (!rise_trip_q || div_done) state_nx = BK_FIN;
			BK_FIN:   state_nx = BK_OUT;
			BK_OUT:   if (load_res) state_nx = BK_IDLE;
			default:  state_nx = BK_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		pop       = 1'b0;
		load_res  = 1'b0;
		div_start = 1'b0;
		div_dvd   = inch_q;
		div_dvs   = DIV_FOOT;
		unique case (state_q)
			BK_IDLE: pop = !q_in.empty;
			BK_DFT:  div_start = !issued_q;
			BK_DMI: begin
				div_start = !issued_q;
				div_dvd   = feet_q;
				div_dvs   = DIV_MILE;
			end
			BK_RTOT: begin
				div_start = rise_tot_q && !issued_q;
				div_dvd   = DIV_W'(sum_tot_q);
				div_dvs   = (unit_tot_q == UNIT_INCH) ? DIV_FOOT : DIV_MILE;
			end
			BK_RTRIP: begin
				div_start = rise_trip_q && !issued_q;
				div_dvd   = DIV_W'(sum_trip_q);
				div_dvs   = (unit_trip_q == UNIT_INCH) ? DIV_FOOT : DIV_MILE;
			end
			BK_OUT:  load_res = !res_valid_q || !res_stall;
			default: ;
		endcase
	end

	// datapath of one root step, the scaling multiply and the adds
	always_comb begin
		sq_sum   = SUM_W'(cmd.dx) * SUM_W'(cmd.dx) + SUM_W'(cmd.dy) * SUM_W'(cmd.dy);
		rrem_sh  = {rrem_q[ROOT_W-1:0], sq_q[SQ_W-1:SQ_W-2]};
		rtrial   = {root_q, 2'b01};
		prod     = PROD_W'(root_q) * PROD_W'(ipp);
		prod_sh  = EXT_W'(prod) >> SHIFT;
		inch_nx  = ((prod_sh >> DIV_W) != '0) ? {DIV_W{1'b1}} : prod_sh[DIV_W-1:0];
		add_tot  = add_sat(acc_tot_q, unit_tot_q, inch_q, feet_q, mile_q);
		add_trip = add_sat(acc_trip_q, unit_trip_q, inch_q, feet_q, mile_q);
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				sq_q   <= {1'(0), sq_sum, (2 * ROOT_FRAC_BITS)'(0)};
				root_q <= '0;
				rrem_q <= '0;
			end
			BK_ROOT: begin
				sq_q <= {sq_q[SQ_W-3:0], 2'b00};
				if (rrem_sh >= rtrial) begin
					rrem_q <= rrem_sh - rtrial;
					root_q <= {root_q[ROOT_W-2:0], 1'b1};
				end else begin
					rrem_q <= rrem_sh;
					root_q <= {root_q[ROOT_W-2:0], 1'b0};
				end
			end
			BK_MUL: inch_q <= inch_nx;
			BK_DFT: if (div_done) feet_q <= div_quo;
			BK_DMI: if (div_done) mile_q <= div_quo;
			BK_ADD: begin
				sum_tot_q   <= add_tot;
				sum_trip_q  <= add_trip;
				nu_tot_q    <= unit_tot_q;
				nu_trip_q   <= unit_trip_q;
				rise_tot_q  <= (unit_tot_q == UNIT_INCH && add_tot >= FOOT_LIM) ||
					(unit_tot_q == UNIT_FOOT && add_tot >= MILE_LIM);
				rise_trip_q <= (unit_trip_q == UNIT_INCH && add_trip >= FOOT_LIM) ||
					(unit_trip_q == UNIT_FOOT && add_trip >= MILE_LIM);
				odig_tot_q  <= digit(acc_tot_q, unit_tot_q);
				odig_trip_q <= digit(acc_trip_q, unit_trip_q);
			end
			BK_RTOT: if (rise_tot_q && div_done) begin
				sum_tot_q <= div_quo[ACC_BITS-1:0];
				nu_tot_q  <= (unit_tot_q == UNIT_INCH) ? UNIT_FOOT : UNIT_MILE;
			end
			BK_RTRIP: if (rise_trip_q && div_done) begin
				sum_trip_q <= div_quo[ACC_BITS-1:0];
				nu_trip_q  <= (unit_trip_q == UNIT_INCH) ? UNIT_FOOT : UNIT_MILE;
			end
			default: ;
		endcase
		if (load_res) begin
			res_q.changed     <= chg_q;
			res_q.total_value <= acc_tot_q;
			res_q.total_unit  <= unit_tot_q;
			res_q.trip_value  <= acc_trip_q;
			res_q.trip_unit   <= unit_trip_q;
		end
	end

	// control and odometer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			cnt_q       <= '0;
			issued_q    <= 1'b0;
			chg_q       <= 1'b0;
			acc_tot_q   <= '0;
			acc_trip_q  <= '0;
			unit_tot_q  <= UNIT_INCH;
			unit_trip_q <= UNIT_INCH;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (div_start)     issued_q <= 1'b1;
			else if (div_done) issued_q <= 1'b0;
			if (state_q == BK_ROOT) cnt_q <= cnt_q + 1'b1;
			else                    cnt_q <= '0;
			if (pop) begin
				chg_q <= 1'b0;
				case (cmd.kind)
					CMD_RST_TRIP: begin
						chg_q       <= 1'b1;
						acc_trip_q  <= '0;
						unit_trip_q <= UNIT_INCH;
					end
					CMD_RST_ALL: begin
						chg_q       <= 1'b1;
						acc_trip_q  <= '0;
						unit_trip_q <= UNIT_INCH;
						acc_tot_q   <= '0;
						unit_tot_q  <= UNIT_INCH;
					end
					default: ;
				endcase
			end
			if (state_q == BK_FIN) begin
				chg_q <= (nu_tot_q != unit_tot_q) || (nu_trip_q != unit_trip_q) ||
					(digit(sum_tot_q, nu_tot_q) != odig_tot_q) ||
					(digit(sum_trip_q, nu_trip_q) != odig_trip_q);
				acc_tot_q   <= sum_tot_q;
				acc_trip_q  <= sum_trip_q;
				unit_tot_q  <= nu_tot_q;
				unit_trip_q <= nu_trip_q;
			end
			if (load_res)                    res_valid_q <= 1'b1;
			else if (res_valid_q && !res_stall) res_valid_q <= 1'b0;
		end
	end

	`PTODO_ASSERT(a_bk_pop_idle, clk, arst_n, pop |-> state_q == BK_IDLE, "pop outside idle")
	`PTODO_ASSERT(a_bk_load_free, clk, arst_n, load_res |-> (!res_valid_q || !res_stall), "result overwritten")

endmodule
`default_nettype wire

[src/pointer_travel_odometer.sv]
// Pointer travel odometer.
// Request channel (req_valid, req_stall, req): one word per pointer sample or
// odometer reset; a word is taken when req_valid is high and req_stall low.
// Result channel (res_valid, res_stall, res): exactly one word per request,
// showing both odometers (value and unit) after it, plus the changed flag.
// Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data): index 0
// is the enable bit, index 1 the inches-per-pixel scale; always ready.
// A sample that moves goes through a 29-bit square root, one scaling
// multiply, two constant divisions for feet and miles, and one more
// division per odometer that changes unit, all in a shared reciprocal
// divider. Other requests go straight to the result word.
// A two-word queue lets the front take up to two words while the back works.
// Reset clears both odometers to zero inches, the last position to (0,0),
// sets enable and the default scale. While res_stall is high the result word
// holds; once the queue is full req_stall rises.
`default_nettype none
module pointer_travel_odometer import ptodo_pkg::*; #(
	parameter int FRAC_BITS      = 32,
	parameter int ROOT_FRAC_BITS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_stall,
	input  wire req_word_t           req,
	output logic                     res_valid,
	input  wire logic                res_stall,
	output res_word_t                res,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [IPP_BITS-1:0] cfg_data
);

	logic                enabled_q;
	logic [IPP_BITS-1:0] ipp_q;
	logic                push, q_full, q_empty;
	cmd_t                cmd_w, cmd_r;
	q_wr_ctl_t           wr_ctl;
	q_rd_ctl_t           rd_ctl_in, rd_ctl_out;

	assign cfg_ready       = 1'b1;
	assign wr_ctl.push     = push;
	assign wr_ctl.full     = q_full;
	assign rd_ctl_in.pop   = 1'b0;
	assign rd_ctl_in.empty = q_empty;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b1;
			ipp_q     <= 32'd45454545;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ENABLED: enabled_q <= cfg_data[0];
				CFG_IPP:     ipp_q     <= cfg_data;
				default:     ;
			endcase
		end
	end

	ptodo_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.enabled   (enabled_q),
		.q_full    (q_full),
		.push      (push),
		.cmd       (cmd_w)
	);

	ptodo_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_in   (wr_ctl),
		.full    (q_full),
		.wr_data (cmd_w),
		.rd_in   (rd_ctl_out),
		.empty   (q_empty),
		.head    (cmd_r)
	);

	ptodo_back #(
		.FRAC_BITS      (FRAC_BITS),
		.ROOT_FRAC_BITS (ROOT_FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.ipp       (ipp_q),
		.q_in      (rd_ctl_in),
		.q_out     (rd_ctl_out),
		.cmd       (cmd_r),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule
`default_nettype wire
